### rtl/mfd_pkg.sv
// mfd_pkg: shared constants and types for the message frame deframer
// no dependencies; used by message_frame_deframer
`default_nettype none

package mfd_pkg;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_LENGTH_LIMIT   = 1'b0,
    REG_TRAILER_MARKER = 1'b1
  } reg_index_t;

  localparam int unsigned LenW    = 13;
  localparam int unsigned PosW    = 14;
  localparam int unsigned TypeW   = 12;
  localparam int unsigned FlagsW  = 7;
  localparam int unsigned HdrW    = 32;
  localparam int unsigned TypeLsb  = 20;
  localparam int unsigned FlagsLsb = 13;
  localparam int unsigned HdrBytes = 4;

  localparam logic [LenW-1:0] LenFieldMask = 13'h1fff;
  localparam logic [LenW-1:0] ResetLimit   = 13'd1400;
  localparam logic [31:0]     ResetMarker  = 32'hFF8859EA;

  // output result kinds
  localparam logic KindPayload = 1'b0;
  localparam logic KindStatus  = 1'b1;

  // m_tdata layout, highest bit first
  typedef struct packed {
    logic [6:0]        pad;
    logic              frame_ok;
    logic [LenW-1:0]   msg_length;
    logic [FlagsW-1:0] msg_flags;
    logic [TypeW-1:0]  msg_type;
    logic [7:0]        payload_byte;
  } out_data_t;

endpackage

`default_nettype wire

### rtl/message_frame_deframer.sv
// message_frame_deframer: splits a framed receive byte stream into payload bytes
// and one end-of-frame status per frame; uses mfd_pkg
// a byte's result is registered into the output register as the byte is taken
// throughput: one byte per cycle while m_tready allows; a new byte is taken while the held result drains
// reset (rst, synchronous, active high): position, header, mismatch cleared,
//   length_limit 1400, trailer_marker 0xFF8859EA, output register emptied
`default_nettype none

module message_frame_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // receive byte stream
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  // result stream
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [47:0] m_tdata,   // payload_byte, msg_type, msg_flags, msg_length,
                                      // frame_ok, zero fill
  output      logic [0:0]  m_tuser,   // [0] kind
  output      logic        m_tlast    // last
);

  localparam int unsigned LenW = mfd_pkg::LenW;
  localparam int unsigned PosW = mfd_pkg::PosW;
  // wide enough for position compares past the padded length
  localparam int unsigned CmpW = PosW + 1;

  // configuration registers
  logic [LenW-1:0] length_limit;
  logic [31:0]     trailer_marker;

  // frame state
  logic [PosW-1:0] byte_position;
  logic [31:0]     header_word;
  logic            trailer_mismatch;

  // output register
  mfd_pkg::out_data_t out_data;
  logic               out_kind;
  logic               out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit   <= mfd_pkg::ResetLimit;
      trailer_marker <= mfd_pkg::ResetMarker;
    end else if (cfg_we) begin
      case (mfd_pkg::reg_index_t'(cfg_index))
        mfd_pkg::REG_LENGTH_LIMIT:   length_limit   <= cfg_data[LenW-1:0];
        mfd_pkg::REG_TRAILER_MARKER: trailer_marker <= cfg_data;
        default: ;
      endcase
    end
  end

  // the output register frees up when empty or when its transfer completes
  assign s_tready = !m_tvalid || m_tready;

  logic in_xfer;
  assign in_xfer = s_tvalid && s_tready;

  // ---- per-byte decode ----
  logic [LenW-1:0] hdr_len;
  logic [LenW-1:0] clamp_len;
  logic [CmpW-1:0] pos_w;
  logic [CmpW-1:0] padded;
  logic [CmpW-1:0] payload_end;   // 4 + len
  logic [CmpW-1:0] padding_end;   // 4 + padded
  logic [CmpW-1:0] trailer_k;
  logic [1:0]      k_sel;
  logic [7:0]      expect_byte;
  logic            in_header;
  logic            in_payload;
  logic            in_padding;
  logic            trailer_end;
  logic            byte_bad;

  assign hdr_len   = header_word[LenW-1:0] & mfd_pkg::LenFieldMask;
  assign clamp_len = (hdr_len > length_limit) ? length_limit : hdr_len;
  assign pos_w     = CmpW'(byte_position);
  // round up to a multiple of four
  assign padded      = (CmpW'(clamp_len) + CmpW'(3)) & ~CmpW'(3);
  assign payload_end = CmpW'(mfd_pkg::HdrBytes) + CmpW'(clamp_len);
  assign padding_end = CmpW'(mfd_pkg::HdrBytes) + padded;

  assign in_header  = pos_w < CmpW'(mfd_pkg::HdrBytes);
  assign in_payload = !in_header && (pos_w < payload_end);
  assign in_padding = !in_header && !in_payload && (pos_w < padding_end);

  // trailer byte index, held at the last byte if the limit moved mid-frame
  assign trailer_k   = pos_w - padding_end;
  assign k_sel       = (trailer_k > CmpW'(3)) ? 2'd3 : trailer_k[1:0];
  assign trailer_end = (k_sel == 2'd3);

  always_comb begin
    case (k_sel)
      2'd0:    expect_byte = trailer_marker[7:0];
      2'd1:    expect_byte = trailer_marker[15:8];
      2'd2:    expect_byte = trailer_marker[23:16];
      default: expect_byte = trailer_marker[31:24];
    endcase
  end

  assign byte_bad = (s_tdata != expect_byte);

  // header word with this byte merged in at its little-endian place
  logic [31:0] header_next;
  always_comb begin
    header_next = header_word;
    case (byte_position[1:0])
      2'd0:    header_next[7:0]   = s_tdata;
      2'd1:    header_next[15:8]  = s_tdata;
      2'd2:    header_next[23:16] = s_tdata;
      default: header_next[31:24] = s_tdata;
    endcase
  end

  logic emit;
  assign emit = in_payload || (!in_header && !in_padding && trailer_end);

  // ---- state update ----
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      header_word      <= '0;
      trailer_mismatch <= 1'b0;
    end else if (in_xfer) begin
      if (in_header) begin
        header_word   <= header_next;
        byte_position <= byte_position + PosW'(1);
      end else if (in_payload || in_padding) begin
        byte_position <= byte_position + PosW'(1);
      end else if (trailer_end) begin
        // frame closes, look for the next header
        byte_position    <= '0;
        trailer_mismatch <= 1'b0;
      end else begin
        byte_position <= byte_position + PosW'(1);
        if (byte_bad) begin
          trailer_mismatch <= 1'b1;
        end
      end
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_xfer && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      out_data.pad        <= '0;
      out_data.msg_type   <= header_word[mfd_pkg::TypeLsb +: mfd_pkg::TypeW];
      out_data.msg_flags  <= header_word[mfd_pkg::FlagsLsb +: mfd_pkg::FlagsW];
      out_data.msg_length <= clamp_len;
      if (in_payload) begin
        out_data.payload_byte <= s_tdata;
        out_data.frame_ok     <= 1'b0;
        out_kind              <= mfd_pkg::KindPayload;
        out_last              <= 1'b0;
      end else begin
        // the last trailer byte counts toward the mismatch too
        out_data.payload_byte <= 8'd0;
        out_data.frame_ok     <= !(trailer_mismatch || byte_bad);
        out_kind              <= mfd_pkg::KindStatus;
        out_last              <= 1'b1;
      end
    end
  end

  assign m_tdata    = out_data;
  assign m_tuser[0] = out_kind;
  assign m_tlast    = out_last;

  // ---- assertions ----
  // the status result and only it carries tlast
  a_last_is_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser[0] == mfd_pkg::KindStatus)))
    else $error("tlast and kind disagree");

  // payload results never claim a good frame
  a_payload_not_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[0] == mfd_pkg::KindPayload)) |-> !out_data.frame_ok)
    else $error("frame_ok set on a payload result");

  // closing a frame restarts the position and clears the mismatch
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && emit && !in_payload) |=> (byte_position == '0 && !trailer_mismatch))
    else $error("frame state not cleared after status");

  // header bytes produce no result
  a_header_silent: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && in_header) |-> !emit)
    else $error("result raised on a header byte");

endmodule

`default_nettype wire
